@@ rtl/hsv2rgb_pkg.sv @@
// ============================================================================
// HSV to RGB conversion package
// Shared payload types, sector codes and fixed constants of the colour
// converter.
// ============================================================================
package hsv2rgb_pkg;

  // Default number of fractional bits of the internal fixed-point format.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Widths of the request and result fields.
  localparam int unsigned IN_HUE_W = 15;
  localparam int unsigned IN_PCT_W = 13;
  localparam int unsigned CHAN_W   = 8;

  // Saturation limits: 359 degrees and 100 percent in 1/64 units.
  localparam int unsigned HUE_MAX     = 22976;
  localparam int unsigned PCT_MAX     = 6400;
  localparam int unsigned SECTOR_SIZE = 3840;

  // Both divisors share a factor of 256, which is taken off as a shift. The
  // rounding offsets 3200 and 1920 then leave a bias of 12 and 7 after it.
  localparam int unsigned PRE_SHIFT = 8;
  localparam int unsigned SAT_DIV   = PCT_MAX >> PRE_SHIFT;
  localparam int unsigned HUE_DIV   = SECTOR_SIZE >> PRE_SHIFT;
  localparam int unsigned SAT_BIAS  = (PCT_MAX / 2) >> PRE_SHIFT;
  localparam int unsigned HUE_BIAS  = (SECTOR_SIZE / 2) >> PRE_SHIFT;

  // Bits needed for a clamped percentage and for a hue within its sector.
  localparam int unsigned PCT_BITS = $clog2(PCT_MAX + 1);
  localparam int unsigned HR_BITS  = $clog2(SECTOR_SIZE);

  // Hue sectors of 60 degrees each, named after their starting colour.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  typedef struct packed {
    logic [IN_HUE_W-1:0] hue;
    logic [IN_PCT_W-1:0] saturation;
    logic [IN_PCT_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

@@ rtl/hsv_to_rgb_convert_unit.sv @@
// ============================================================================
// HSV to RGB conversion unit
// Pipelined conversion of one HSV colour a cycle, while results are taken, into an 8-bit RGB triple.
// ============================================================================
// A request on the input channel carries hue in 1/64 degree, saturation and
// brightness in 1/64 percent; each is clamped to its full-scale value first.
// The result channel returns one red, green and blue triple per request, in
// request order, each channel rounded half up to 0..255.
//
// The pipeline has five register stages. A request accepted into the front
// stage passes through the divide and the two product stages into the result
// register, where its result stays offered until the receiver takes it. One
// request is accepted every cycle while the receiver keeps taking results;
// the rate is set by the stage-by-stage handshake, each stage holding one
// request and its valid bit.
//
// A stalled receiver holds only the stages that cannot move: empty stages
// further up keep filling, so requests are still accepted until every stage
// holds one. Nothing is dropped or repeated across a stall.
//
// Reset clears the valid bits only; the unit has no other control state, and after
// reset it accepts a request in the first cycle.
// ============================================================================
module hsv_to_rgb_convert_unit #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsv2rgb_pkg::hsv_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsv2rgb_pkg::rgb_t out_data_o
);

  // Stage order: front, divide, two product stages, channel select.
  localparam int unsigned NSTG = 5;
  localparam int unsigned SH   = FRAC_BITS - hsv2rgb_pkg::PRE_SHIFT;
  localparam int unsigned XS_W = hsv2rgb_pkg::PCT_BITS + SH;
  localparam int unsigned XF_W = hsv2rgb_pkg::HR_BITS + SH;

  logic [NSTG-1:0] vld_d, vld_q;
  logic [NSTG-1:0] en;

  logic [XS_W-1:0]        xs, xv;
  logic [XF_W-1:0]        xf;
  hsv2rgb_pkg::sector_e   sector0, sector1_q, sector3;
  logic [FRAC_BITS:0]     s_fx, v_fx;
  logic [FRAC_BITS-1:0]   f_fx;
  logic [FRAC_BITS:0]     p3, q3, t3, v3;

  // A stage may load when it is empty or when the stage after it moves on
  // in the same cycle. The chain starts at the result register.
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSTG-1];

  // Stage one: clamp, hue sector and division numerators.
  hsv2rgb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .en_i     (en[0]),
    .in_i     (in_data_i),
    .xs_o     (xs),
    .xv_o     (xv),
    .xf_o     (xf),
    .sector_o (sector0)
  );

  // Stage two: saturation, value and hue fraction in fixed point. The
  // sector rides alongside in its own register.
  hsv2rgb_cdiv #(
    .XW      (XS_W),
    .QW      (FRAC_BITS + 1),
    .DIVISOR (hsv2rgb_pkg::SAT_DIV)
  ) u_div_s (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .x_i   (xs),
    .q_o   (s_fx)
  );

  hsv2rgb_cdiv #(
    .XW      (XS_W),
    .QW      (FRAC_BITS + 1),
    .DIVISOR (hsv2rgb_pkg::SAT_DIV)
  ) u_div_v (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .x_i   (xv),
    .q_o   (v_fx)
  );

  hsv2rgb_cdiv #(
    .XW      (XF_W),
    .QW      (FRAC_BITS),
    .DIVISOR (hsv2rgb_pkg::HUE_DIV)
  ) u_div_f (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .x_i   (xf),
    .q_o   (f_fx)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sector1_q <= sector0;
    end
  end

  // Stages three and four: p, q and t. With zero saturation all three equal
  // the value, so grey needs no path of its own.
  hsv2rgb_pqt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pqt (
    .clk_i    (clk_i),
    .en_a_i   (en[2]),
    .en_b_i   (en[3]),
    .s_i      (s_fx),
    .v_i      (v_fx),
    .f_i      (f_fx),
    .sector_i (sector1_q),
    .p_o      (p3),
    .q_o      (q3),
    .t_o      (t3),
    .v_o      (v3),
    .sector_o (sector3)
  );

  // Stage five: channel routing, scaling and the result register.
  hsv2rgb_pick #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pick (
    .clk_i    (clk_i),
    .en_i     (en[NSTG-1]),
    .p_i      (p3),
    .q_i      (q3),
    .t_i      (t3),
    .v_i      (v3),
    .sector_i (sector3),
    .out_o    (out_data_o)
  );

endmodule

@@ rtl/hsv2rgb_front.sv @@
// ============================================================================
// HSV to RGB front stage
// Clamps the request fields, finds the hue sector and forms the numerators
// of the three constant divisions.
// ============================================================================
module hsv2rgb_front #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  hsv2rgb_pkg::hsv_t                             in_i,
  output logic [hsv2rgb_pkg::PCT_BITS+FRAC_BITS-hsv2rgb_pkg::PRE_SHIFT-1:0] xs_o,
  output logic [hsv2rgb_pkg::PCT_BITS+FRAC_BITS-hsv2rgb_pkg::PRE_SHIFT-1:0] xv_o,
  output logic [hsv2rgb_pkg::HR_BITS+FRAC_BITS-hsv2rgb_pkg::PRE_SHIFT-1:0]  xf_o,
  output hsv2rgb_pkg::sector_e                          sector_o
);

  localparam int unsigned SH   = FRAC_BITS - hsv2rgb_pkg::PRE_SHIFT;
  localparam int unsigned XS_W = hsv2rgb_pkg::PCT_BITS + SH;
  localparam int unsigned XF_W = hsv2rgb_pkg::HR_BITS + SH;
  localparam int unsigned HW   = hsv2rgb_pkg::IN_HUE_W;
  localparam int unsigned PW   = hsv2rgb_pkg::IN_PCT_W;
  localparam int unsigned SS   = hsv2rgb_pkg::SECTOR_SIZE;

  logic [HW-1:0]                    hue_c;
  logic [PW-1:0]                    sat_c;
  logic [PW-1:0]                    val_c;
  logic [HW-1:0]                    base;
  logic [hsv2rgb_pkg::HR_BITS-1:0]  hue_rem;
  hsv2rgb_pkg::sector_e             sector_d, sector_q;
  logic [XS_W-1:0]                  xs_d, xs_q;
  logic [XS_W-1:0]                  xv_d, xv_q;
  logic [XF_W-1:0]                  xf_d, xf_q;

  always_comb begin
    hue_c = (in_i.hue > HW'(hsv2rgb_pkg::HUE_MAX)) ? HW'(hsv2rgb_pkg::HUE_MAX) : in_i.hue;
    sat_c = (in_i.saturation > PW'(hsv2rgb_pkg::PCT_MAX)) ?
            PW'(hsv2rgb_pkg::PCT_MAX) : in_i.saturation;
    val_c = (in_i.brightness > PW'(hsv2rgb_pkg::PCT_MAX)) ?
            PW'(hsv2rgb_pkg::PCT_MAX) : in_i.brightness;
  end

  // The clamped hue never reaches six sectors, so the top compare also
  // covers the highest hue.
  always_comb begin
    if (hue_c >= HW'(5 * SS)) begin
      sector_d = hsv2rgb_pkg::SEC_MAGENTA;
      base     = HW'(5 * SS);
    end else if (hue_c >= HW'(4 * SS)) begin
      sector_d = hsv2rgb_pkg::SEC_BLUE;
      base     = HW'(4 * SS);
    end else if (hue_c >= HW'(3 * SS)) begin
      sector_d = hsv2rgb_pkg::SEC_CYAN;
      base     = HW'(3 * SS);
    end else if (hue_c >= HW'(2 * SS)) begin
      sector_d = hsv2rgb_pkg::SEC_GREEN;
      base     = HW'(2 * SS);
    end else if (hue_c >= HW'(SS)) begin
      sector_d = hsv2rgb_pkg::SEC_YELLOW;
      base     = HW'(SS);
    end else begin
      sector_d = hsv2rgb_pkg::SEC_RED;
      base     = '0;
    end
  end

  assign hue_rem = hsv2rgb_pkg::HR_BITS'(hue_c - base);

  assign xs_d = (XS_W'(sat_c) << SH) + XS_W'(hsv2rgb_pkg::SAT_BIAS);
  assign xv_d = (XS_W'(val_c) << SH) + XS_W'(hsv2rgb_pkg::SAT_BIAS);
  assign xf_d = (XF_W'(hue_rem) << SH) + XF_W'(hsv2rgb_pkg::HUE_BIAS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q     <= xs_d;
      xv_q     <= xv_d;
      xf_q     <= xf_d;
      sector_q <= sector_d;
    end
  end

  assign xs_o     = xs_q;
  assign xv_o     = xv_q;
  assign xf_o     = xf_q;
  assign sector_o = sector_q;

endmodule

@@ rtl/hsv2rgb_cdiv.sv @@
// ============================================================================
// HSV to RGB constant divider
// Floor division by a small constant as one registered multiplication by a
// rounded-up reciprocal, exact over the whole numerator range.
// ============================================================================
module hsv2rgb_cdiv #(
  parameter int unsigned XW      = 21,
  parameter int unsigned QW      = 17,
  parameter int unsigned DIVISOR = 25
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [XW-1:0] x_i,
  output logic [QW-1:0] q_o
);

  // With K at least XW plus the divisor's bit count the reciprocal error
  // stays below one unit of the quotient for every numerator.
  localparam int unsigned K = XW + $clog2(DIVISOR);
  localparam longint unsigned RECIP =
      ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int unsigned MW = $clog2(RECIP + 64'd1);
  localparam int unsigned PW = (XW + MW > K + QW) ? XW + MW : K + QW;
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic [PW-1:0] prod_d, prod_q;

  assign prod_d = PW'(x_i) * PW'(RECIP_C);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign q_o = prod_q[K +: QW];

endmodule

@@ rtl/hsv2rgb_pqt.sv @@
// ============================================================================
// HSV to RGB p, q and t stages
// Two register stages of fixed-point products that form p, q and t from
// saturation, value and the hue fraction.
// ============================================================================
module hsv2rgb_pqt #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_a_i,
  input  logic                  en_b_i,
  input  logic [FRAC_BITS:0]    s_i,
  input  logic [FRAC_BITS:0]    v_i,
  input  logic [FRAC_BITS-1:0]  f_i,
  input  hsv2rgb_pkg::sector_e  sector_i,
  output logic [FRAC_BITS:0]    p_o,
  output logic [FRAC_BITS:0]    q_o,
  output logic [FRAC_BITS:0]    t_o,
  output logic [FRAC_BITS:0]    v_o,
  output hsv2rgb_pkg::sector_e  sector_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned MW = 2 * VW;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  logic [VW-1:0]        f_ext;
  logic [MW-1:0]        prod_p, prod_sf, prod_sg, prod_q, prod_t;
  logic [VW-1:0]        p_a_d, sf_a_d, sg_a_d;
  logic [VW-1:0]        p_a_q, sf_a_q, sg_a_q, v_a_q;
  hsv2rgb_pkg::sector_e sector_a_q;
  logic [VW-1:0]        q_b_d, t_b_d;
  logic [VW-1:0]        p_b_q, q_b_q, t_b_q, v_b_q;
  hsv2rgb_pkg::sector_e sector_b_q;

  // First stage: p and the two saturation-fraction products.
  assign f_ext   = VW'(f_i);
  assign prod_p  = MW'(v_i) * MW'(ONE - s_i);
  assign prod_sf = MW'(s_i) * MW'(f_ext);
  assign prod_sg = MW'(s_i) * MW'(ONE - f_ext);
  assign p_a_d   = prod_p[FRAC_BITS +: VW];
  assign sf_a_d  = prod_sf[FRAC_BITS +: VW];
  assign sg_a_d  = prod_sg[FRAC_BITS +: VW];

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      p_a_q      <= p_a_d;
      sf_a_q     <= sf_a_d;
      sg_a_q     <= sg_a_d;
      v_a_q      <= v_i;
      sector_a_q <= sector_i;
    end
  end

  // Second stage: q and t scale the value by the complements.
  assign prod_q = MW'(v_a_q) * MW'(ONE - sf_a_q);
  assign prod_t = MW'(v_a_q) * MW'(ONE - sg_a_q);
  assign q_b_d  = prod_q[FRAC_BITS +: VW];
  assign t_b_d  = prod_t[FRAC_BITS +: VW];

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      p_b_q      <= p_a_q;
      q_b_q      <= q_b_d;
      t_b_q      <= t_b_d;
      v_b_q      <= v_a_q;
      sector_b_q <= sector_a_q;
    end
  end

  assign p_o      = p_b_q;
  assign q_o      = q_b_q;
  assign t_o      = t_b_q;
  assign v_o      = v_b_q;
  assign sector_o = sector_b_q;

endmodule

@@ rtl/hsv2rgb_pick.sv @@
// ============================================================================
// HSV to RGB channel select
// Routes p, q, t and v to the three channels by sector and scales each to
// eight bits, rounding half up, into the result register.
// ============================================================================
module hsv2rgb_pick #(
  parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS:0]   p_i,
  input  logic [FRAC_BITS:0]   q_i,
  input  logic [FRAC_BITS:0]   t_i,
  input  logic [FRAC_BITS:0]   v_i,
  input  hsv2rgb_pkg::sector_e sector_i,
  output hsv2rgb_pkg::rgb_t    out_o
);

  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned AW = VW + hsv2rgb_pkg::CHAN_W;
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  logic [VW-1:0]     r_sel, g_sel, b_sel;
  hsv2rgb_pkg::rgb_t out_d, out_q;

  // x * 255 is x * 256 - x; the value never exceeds one, so no clamp.
  function automatic logic [hsv2rgb_pkg::CHAN_W-1:0] to_chan(input logic [VW-1:0] x);
    logic [AW-1:0] acc;
    acc = (AW'(x) << hsv2rgb_pkg::CHAN_W) - AW'(x) + HALF;
    return acc[FRAC_BITS +: hsv2rgb_pkg::CHAN_W];
  endfunction

  always_comb begin
    case (sector_i)
      hsv2rgb_pkg::SEC_RED: begin
        r_sel = v_i; g_sel = t_i; b_sel = p_i;
      end
      hsv2rgb_pkg::SEC_YELLOW: begin
        r_sel = q_i; g_sel = v_i; b_sel = p_i;
      end
      hsv2rgb_pkg::SEC_GREEN: begin
        r_sel = p_i; g_sel = v_i; b_sel = t_i;
      end
      hsv2rgb_pkg::SEC_CYAN: begin
        r_sel = p_i; g_sel = q_i; b_sel = v_i;
      end
      hsv2rgb_pkg::SEC_BLUE: begin
        r_sel = t_i; g_sel = p_i; b_sel = v_i;
      end
      default: begin
        r_sel = v_i; g_sel = p_i; b_sel = q_i;
      end
    endcase
  end

  always_comb begin
    out_d.red   = to_chan(r_sel);
    out_d.green = to_chan(g_sel);
    out_d.blue  = to_chan(b_sel);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

@@ rtl/hsv2rgb_chk.sv @@
// ============================================================================
// HSV to RGB port checker
// Concurrent checks on the ports of the conversion unit, bound to it.
// ============================================================================
module hsv2rgb_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input hsv2rgb_pkg::hsv_t in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input hsv2rgb_pkg::rgb_t out_data_o
);

  // A result that is not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or vanished while stalled");

  // With no result waiting every stage can move, so a request is taken.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request refused with an empty result register");

  // With the receiver ready throughout, a request that is taken moves through
  // every stage without waiting and is then offered as a result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("result late with the receiver always ready");

  // Zero saturation comes out grey.
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.saturation == '0) ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o && (out_data_o.red == out_data_o.green)
        && (out_data_o.green == out_data_o.blue))
    else $error("zero saturation did not give grey");

endmodule

bind hsv_to_rgb_convert_unit hsv2rgb_chk u_hsv2rgb_chk (.*);
